// ----- sv/threshold_level_edge_marker_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef THRESHOLD_LEVEL_EDGE_MARKER_TOP_DEFINES_SVH
`define THRESHOLD_LEVEL_EDGE_MARKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLEM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlem check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlem check failed");

`endif

// ----- sv/tlem_pkg.sv -----
`default_nettype none

package tlem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int SIZE_W     = 11;
    localparam int THR_W      = 10;
    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_THR      = 3'd4;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd960;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd720;
    localparam logic [THR_W-1:0]  RST_LOW_THR      = 10'd500;
    localparam logic [THR_W-1:0]  RST_HIGH_THR     = 10'd750;
    localparam logic [THR_W-1:0]  RST_SAT_THR      = 10'd765;

    typedef logic [1:0] level_t;

    localparam level_t LVL_DARK  = 2'd0;
    localparam level_t LVL_WHITE = 2'd1;
    localparam level_t LVL_GREY  = 2'd2;

    localparam logic [CHAN_W-1:0] PIX_DARK  = 8'd0;
    localparam logic [CHAN_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [CHAN_W-1:0] PIX_GREY  = 8'd125;
    localparam logic [CHAN_W-1:0] PIX_MARK  = 8'd255;

    function automatic logic [CHAN_W-1:0] level_pixel(level_t lvl);
        logic [CHAN_W-1:0] pix;
        case (lvl)
            LVL_WHITE: pix = PIX_WHITE;
            LVL_GREY:  pix = PIX_GREY;
            default:   pix = PIX_DARK;
        endcase
        return pix;
    endfunction

    function automatic level_t quantize(logic [SUM_W-1:0] sum, logic [THR_W-1:0] low_thr,
                                        logic [THR_W-1:0] high_thr,
                                        logic [THR_W-1:0] sat_thr);
        level_t lvl;
        if (sum == '0)
            lvl = LVL_DARK;
        else if (sum < low_thr)
            lvl = LVL_DARK;
        else if (sum < high_thr)
            lvl = LVL_WHITE;
        else if (sum < sat_thr)
            lvl = LVL_GREY;
        else
            lvl = LVL_DARK;
        return lvl;
    endfunction

    function automatic logic [COL_W:0] clamp_width(logic [SIZE_W-1:0] v);
        logic [COL_W:0] w;
        if (v == '0)
            w = (COL_W+1)'(1);
        else if (int'(v) > MAX_WIDTH)
            w = (COL_W+1)'(MAX_WIDTH);
        else
            w = (COL_W+1)'(v);
        return w;
    endfunction

    function automatic logic [ROW_W:0] clamp_height(logic [SIZE_W-1:0] v);
        logic [ROW_W:0] h;
        if (v == '0)
            h = (ROW_W+1)'(1);
        else if (int'(v) > MAX_HEIGHT)
            h = (ROW_W+1)'(MAX_HEIGHT);
        else
            h = (ROW_W+1)'(v);
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- sv/threshold_level_edge_marker_top.sv -----
// An input transfer loads the stage 1 register, then the result register; results trail
// their pixel by one row. Throughput: one item per cycle unless the output stalls, set by
// the single registered pass through the sum, threshold compares and line buffer read.
// Reset: row/column counters, pending flag and handshake state clear, registers
// take their default values; the level line buffer is not cleared (no clearing pass).
`default_nettype none

module threshold_level_edge_marker_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tlem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tlem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [23:0]                      s_axis_tdata,   // red_in, green_in, blue_in
    input  wire logic                             s_axis_tuser,   // mode
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [23:0]                           m_axis_tdata,   // red_out, green_out, blue_out
    output logic                                  m_axis_tuser,   // is_edge
    output logic                                  m_axis_tlast    // frame_last
);

    localparam int COL_W = tlem_pkg::COL_W;
    localparam int ROW_W = tlem_pkg::ROW_W;
    localparam int CW    = tlem_pkg::CHAN_W;

    // configuration
    logic [tlem_pkg::SIZE_W-1:0] frame_width_reg, frame_height_reg;
    logic [tlem_pkg::THR_W-1:0]  low_thr_reg, high_thr_reg, sat_thr_reg;

    // frame position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             pending_reg, pending_next;

    // stage 1 (input register)
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pixel_reg, s1_emit_reg, s1_has_lower_reg, s1_has_right_reg;
    logic             s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [CW-1:0]    s1_red_reg, s1_green_reg, s1_blue_reg;
    tlem_pkg::level_t q0_reg, q1_reg, fwd_lvl_reg;
    logic             fwd0_reg, fwd1_reg;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    out_red_reg, out_green_reg, out_blue_reg;
    logic             out_edge_reg, out_last_reg;

    tlem_pkg::level_t line_mem [tlem_pkg::MAX_WIDTH];

    logic             accept, s1_adv, is_drain;
    logic [COL_W:0]   w, col_inc;
    logic [ROW_W:0]   h, row_inc;
    logic [COL_W-1:0] col_cur, rd_addr1;
    logic [ROW_W-1:0] row_cur;
    logic             col_wrap, row_wrap, row_zero;

    logic [tlem_pkg::SUM_W-1:0] sum;
    tlem_pkg::level_t           s1_level, old0, old1;
    logic                       edge_hit;
    logic [CW-1:0]              pix;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= tlem_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= tlem_pkg::RST_FRAME_HEIGHT;
            low_thr_reg      <= tlem_pkg::RST_LOW_THR;
            high_thr_reg     <= tlem_pkg::RST_HIGH_THR;
            sat_thr_reg      <= tlem_pkg::RST_SAT_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlem_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                tlem_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                tlem_pkg::REG_LOW_THR:      low_thr_reg      <= cfg_data[tlem_pkg::THR_W-1:0];
                tlem_pkg::REG_HIGH_THR:     high_thr_reg     <= cfg_data[tlem_pkg::THR_W-1:0];
                tlem_pkg::REG_SAT_THR:      sat_thr_reg      <= cfg_data[tlem_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position tracking at input transfer ----------------
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_drain = s_axis_tuser;

    always_comb
    begin
        w        = tlem_pkg::clamp_width(frame_width_reg);
        h        = tlem_pkg::clamp_height(frame_height_reg);
        // counts beyond a shrunken geometry wrap to zero
        col_cur  = ({1'b0, col_reg} >= w) ? '0 : col_reg;
        row_cur  = ({1'b0, row_reg} >= h) ? '0 : row_reg;
        col_inc  = {1'b0, col_cur} + (COL_W+1)'(1);
        row_inc  = {1'b0, row_cur} + (ROW_W+1)'(1);
        col_wrap = (col_inc >= w);
        row_wrap = (row_inc >= h);
        row_zero = (row_cur == '0);
        rd_addr1 = col_inc[COL_W-1:0];

        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        if (accept)
        begin
            if (is_drain)
            begin
                if (pending_reg)
                begin
                    col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
                    if (col_wrap)
                        pending_next = 1'b0;
                end
            end
            else
            begin
                col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
                row_next = row_cur;
                if (col_wrap)
                begin
                    if (row_zero)
                        pending_next = 1'b0;
                    row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
                    if (row_wrap)
                        pending_next = 1'b1;
                end
            end
        end
    end

    // ---------------- stage 1: level, edge decision ----------------
    always_comb
    begin
        sum = {2'b00, s1_red_reg} + {2'b00, s1_green_reg} + {2'b00, s1_blue_reg};
        s1_level = tlem_pkg::quantize(sum, low_thr_reg, high_thr_reg, sat_thr_reg);
        // the previous item's write lands on the same edge as our read
        old0 = fwd0_reg ? fwd_lvl_reg : q0_reg;
        old1 = fwd1_reg ? fwd_lvl_reg : q1_reg;
        edge_hit = (s1_has_right_reg && (old1 != old0))
                || (s1_has_lower_reg && (s1_level != old0));
        pix = tlem_pkg::level_pixel(old0);
    end

    assign s1_adv        = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (accept)
            s1_valid_next = !is_drain || pending_reg;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && s1_emit_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            pending_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            pending_reg   <= pending_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 1 payload and line buffer reads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg     <= !is_drain;
            s1_emit_reg      <= is_drain || !row_zero || pending_reg;
            s1_has_lower_reg <= !is_drain && !row_zero;
            s1_has_right_reg <= !col_wrap;
            s1_last_reg      <= (is_drain || row_zero) && col_wrap;
            s1_col_reg       <= col_cur;
            s1_red_reg       <= s_axis_tdata[7:0];
            s1_green_reg     <= s_axis_tdata[15:8];
            s1_blue_reg      <= s_axis_tdata[23:16];
            q0_reg           <= line_mem[col_cur];
            q1_reg           <= line_mem[rd_addr1];
            fwd0_reg         <= s1_adv && s1_pixel_reg && (s1_col_reg == col_cur);
            fwd1_reg         <= s1_adv && s1_pixel_reg && (s1_col_reg == rd_addr1);
            fwd_lvl_reg      <= s1_level;
        end
        if (s1_adv && s1_pixel_reg)
            line_mem[s1_col_reg] <= s1_level;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_red_reg   <= edge_hit ? tlem_pkg::PIX_MARK : pix;
            out_green_reg <= edge_hit ? tlem_pkg::PIX_DARK : pix;
            out_blue_reg  <= edge_hit ? tlem_pkg::PIX_DARK : pix;
            out_edge_reg  <= edge_hit;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_blue_reg, out_green_reg, out_red_reg};
    assign m_axis_tuser  = out_edge_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/tlem_checker.sv -----
`default_nettype none

`include "threshold_level_edge_marker_top_defines.svh"

module tlem_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result holds
    `TLEM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // marked pixels are pure red
    `TLEM_ASSERT_NOW(a_edge_red, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'h0000FF)

    // unmarked pixels are grey at one of the three levels
    `TLEM_ASSERT_NOW(a_grey_level, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[7:0] == m_axis_tdata[15:8]) && (m_axis_tdata[15:8] == m_axis_tdata[23:16]) && ((m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[7:0] == 8'd125) || (m_axis_tdata[7:0] == 8'd255)))

    // a fresh result is caused by an earlier input transfer
    `TLEM_ASSERT_NOW(a_result_cause, m_axis_tvalid && !$past(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind threshold_level_edge_marker_top tlem_checker u_tlem_checker (.*);

`default_nettype wire
